FILE: design/pin_lock_motion_alarm_defines.svh
// ----------------------------------------------------------------------------
// Pin lock motion alarm: assertion macros
// Concurrent assertion forms for the alarm top level.
// ----------------------------------------------------------------------------
`ifndef PIN_LOCK_MOTION_ALARM_DEFINES_SVH
`define PIN_LOCK_MOTION_ALARM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMLA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pin lock alarm check failed");

// Consequent must hold in the cycle after the antecedent.
`define PMLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pin lock alarm check failed");

`endif

FILE: design/pmla_pkg.sv
// ----------------------------------------------------------------------------
// Pin lock motion alarm package
// Types, codes and reset values shared by the alarm modules.
// ----------------------------------------------------------------------------
package pmla_pkg;

  typedef enum logic [1:0] {
    LOCK_DISARMED  = 2'd0,
    LOCK_ARMED     = 2'd1,
    LOCK_DISARMING = 2'd2
  } lock_state_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ARMED    = 3'd1,
    EV_ALARM    = 3'd2,
    EV_DISARMED = 3'd3,
    EV_WRONG    = 3'd4
  } event_e;

  // configuration register indexes
  localparam logic [1:0] CFG_Z_LOW     = 2'd0;
  localparam logic [1:0] CFG_Z_HIGH    = 2'd1;
  localparam logic [1:0] CFG_MOTION_LM = 2'd2;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_CLEAR = 8'h2A; // '*'
  localparam logic [7:0] KEY_ENTER = 8'h23; // '#'
  localparam logic [7:0] PIN_RESET_CODE = 8'h30; // '0'

  localparam logic signed [15:0] Z_LOW_RESET  = 16'sd12000;
  localparam logic signed [15:0] Z_HIGH_RESET = 16'sd20000;
  localparam logic [7:0]         MOTION_LIMIT_RESET = 8'd5;
  localparam logic [7:0]         MOTION_CNT_TOP     = 8'hFF;

  typedef struct packed {
    logic              mode;     // 0 key beat, 1 Z sample
    logic [7:0]        key_code;
    logic signed [15:0] z_sample;
  } item_t;

  typedef struct packed {
    lock_state_e lock_state;
    logic        buzzer_on;
    event_e      event_code;
    logic [2:0]  digits_entered;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  idx;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

FILE: design/pmla_core.sv
// ----------------------------------------------------------------------------
// Pin lock motion alarm core
// Configuration registers, lock state and the combinational update logic.
// ----------------------------------------------------------------------------
module pmla_core #(
  parameter int PIN_LENGTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmla_pkg::cfg_wr_t cfg_i,
  input  logic              step_i,   // item in the input register is consumed
  input  pmla_pkg::item_t   item_i,
  output pmla_pkg::result_t res_o     // result after this item's update
);

  localparam int CntW = $clog2(PIN_LENGTH + 1);

  logic signed [15:0] z_low_q, z_high_q;
  logic [7:0]         motion_limit_q;

  pmla_pkg::lock_state_e state_q, state_d;
  logic [7:0]            pin_q   [PIN_LENGTH];
  logic [7:0]            pin_d   [PIN_LENGTH];
  logic [7:0]            entry_q [PIN_LENGTH];
  logic [7:0]            entry_d [PIN_LENGTH];
  logic [CntW-1:0]       count_q, count_d;
  logic [7:0]            motion_q, motion_d;
  logic                  siren_q, siren_d;

  pmla_pkg::event_e ev;
  logic             match;
  logic             out_win;
  logic [7:0]       motion_inc;
  logic [CntW+2:0]  count_ext;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_low_q        <= pmla_pkg::Z_LOW_RESET;
      z_high_q       <= pmla_pkg::Z_HIGH_RESET;
      motion_limit_q <= pmla_pkg::MOTION_LIMIT_RESET;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        pmla_pkg::CFG_Z_LOW:     z_low_q        <= cfg_i.data;
        pmla_pkg::CFG_Z_HIGH:    z_high_q       <= cfg_i.data;
        pmla_pkg::CFG_MOTION_LM: motion_limit_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    match = (count_q == CntW'(PIN_LENGTH));
    for (int i = 0; i < PIN_LENGTH; i++) begin
      if (entry_q[i] != pin_q[i]) match = 1'b0;
    end
  end

  assign out_win    = (item_i.z_sample < z_low_q) || (item_i.z_sample > z_high_q);
  assign motion_inc = (motion_q != pmla_pkg::MOTION_CNT_TOP) ? motion_q + 8'd1 : motion_q;

  always_comb begin
    state_d  = state_q;
    pin_d    = pin_q;
    entry_d  = entry_q;
    count_d  = count_q;
    motion_d = motion_q;
    siren_d  = siren_q;
    ev       = pmla_pkg::EV_NONE;

    if (!item_i.mode) begin
      if (item_i.key_code != pmla_pkg::KEY_NONE &&
          (state_q == pmla_pkg::LOCK_DISARMED || state_q == pmla_pkg::LOCK_DISARMING)) begin
        priority if (item_i.key_code == pmla_pkg::KEY_CLEAR) begin
          for (int i = 0; i < PIN_LENGTH; i++) entry_d[i] = '0;
          count_d = '0;
        end else if (item_i.key_code == pmla_pkg::KEY_ENTER) begin
          if (state_q == pmla_pkg::LOCK_DISARMED) begin
            if (count_q == CntW'(PIN_LENGTH)) begin
              pin_d = entry_q;
              for (int i = 0; i < PIN_LENGTH; i++) entry_d[i] = '0;
              count_d = '0;
              state_d = pmla_pkg::LOCK_ARMED;
              ev      = pmla_pkg::EV_ARMED;
            end
          end else begin
            if (match) begin
              siren_d = 1'b0;
              state_d = pmla_pkg::LOCK_DISARMED;
              ev      = pmla_pkg::EV_DISARMED;
            end else begin
              ev      = pmla_pkg::EV_WRONG;
            end
            for (int i = 0; i < PIN_LENGTH; i++) entry_d[i] = '0;
            count_d = '0;
          end
        end else begin
          // digit (any other code); full entry ignores it
          if (count_q < CntW'(PIN_LENGTH)) begin
            for (int i = 0; i < PIN_LENGTH; i++) begin
              if (count_q == CntW'(i)) entry_d[i] = item_i.key_code;
            end
            count_d = count_q + CntW'(1);
          end
        end
      end
    end else if (state_q == pmla_pkg::LOCK_ARMED) begin
      if (out_win) begin
        motion_d = motion_inc;
        if (motion_inc >= motion_limit_q) begin
          siren_d  = 1'b1;
          for (int i = 0; i < PIN_LENGTH; i++) entry_d[i] = '0;
          count_d  = '0;
          motion_d = '0;
          state_d  = pmla_pkg::LOCK_DISARMING;
          ev       = pmla_pkg::EV_ALARM;
        end
      end else begin
        motion_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pmla_pkg::LOCK_DISARMED;
      count_q  <= '0;
      motion_q <= '0;
      siren_q  <= 1'b0;
      for (int i = 0; i < PIN_LENGTH; i++) begin
        pin_q[i]   <= pmla_pkg::PIN_RESET_CODE;
        entry_q[i] <= '0;
      end
    end else if (step_i) begin
      state_q  <= state_d;
      count_q  <= count_d;
      motion_q <= motion_d;
      siren_q  <= siren_d;
      pin_q    <= pin_d;
      entry_q  <= entry_d;
    end
  end

  assign count_ext = {3'b000, count_d};

  always_comb begin
    res_o.lock_state     = state_d;
    res_o.buzzer_on      = siren_d;
    res_o.event_code     = ev;
    res_o.digits_entered = count_ext[2:0];
  end

endmodule

FILE: design/pin_lock_motion_alarm.sv
// ----------------------------------------------------------------------------
// Pin lock motion alarm top level
// Keypad PIN lock with an accelerometer motion alarm, one beat per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one beat is either a key event
//   (mode_i = 0, key_code_i) or a Z sample (mode_i = 1, z_sample_i).
//   Output channel (out_valid_o/out_ready_i): exactly one result beat per
//   input beat, in order, showing state, siren, event and entry count after
//   that beat's update.
//   Config channel (cfg_valid_i/cfg_ready_o): index 0 Z low limit, 1 Z high
//   limit, 2 motion limit; always ready. Write only while the block is idle.
// Path: an accepted beat waits in the input register, then moves into the
//   result register, loaded by the combinational update in the core, once
//   the result stage is free.
// Throughput: one beat per cycle unless out_ready_i stalls; the lock state
//   update is one pass of short logic between input and result registers.
// Reset: disarmed, PIN "0000", entry empty, siren off, limits 12000/20000/5;
//   both pipeline stages empty.
// Stall: with out_ready_i low the result holds and the input register still
//   takes one more beat, after which in_ready_o drops.
// ----------------------------------------------------------------------------
`include "pin_lock_motion_alarm_defines.svh"

module pin_lock_motion_alarm #(
  parameter int PIN_LENGTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [7:0]         key_code_i,
  input  logic signed [15:0] z_sample_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         lock_state_o,
  output logic               buzzer_on_o,
  output logic [2:0]         event_code_o,
  output logic [2:0]         digits_entered_o
);

  pmla_pkg::item_t   item_q;
  logic              in_valid_q;
  pmla_pkg::result_t res_d, res_q;
  logic              out_valid_q;
  pmla_pkg::cfg_wr_t cfg_wr;
  logic              step;   // input register hands its beat to the core
  logic              in_acc;

  // the result stage frees up when empty or when its beat is being taken
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_wr.we   = cfg_valid_i;
    cfg_wr.idx  = cfg_index_i;
    cfg_wr.data = cfg_data_i;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.mode     <= mode_i;
      item_q.key_code <= key_code_i;
      item_q.z_sample <= z_sample_i;
    end
  end

  pmla_core #(
    .PIN_LENGTH(PIN_LENGTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr),
    .step_i (step),
    .item_i (item_q),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign lock_state_o     = res_q.lock_state;
  assign buzzer_on_o      = res_q.buzzer_on;
  assign event_code_o     = res_q.event_code;
  assign digits_entered_o = res_q.digits_entered;

  // siren only sounds while waiting for the PIN after an alarm
  `PMLA_ASSERT_SAME(a_siren_state, clk_i, rst_ni,
                    out_valid_q && res_q.buzzer_on,
                    res_q.lock_state == pmla_pkg::LOCK_DISARMING)
  // an alarm beat always carries the siren
  `PMLA_ASSERT_SAME(a_alarm_siren, clk_i, rst_ni,
                    out_valid_q && res_q.event_code == pmla_pkg::EV_ALARM,
                    res_q.buzzer_on)
  // arming leaves the lock armed with an empty entry
  `PMLA_ASSERT_SAME(a_armed_clean, clk_i, rst_ni,
                    out_valid_q && res_q.event_code == pmla_pkg::EV_ARMED,
                    res_q.lock_state == pmla_pkg::LOCK_ARMED && res_q.digits_entered == 3'd0)
  // a held beat with an empty result stage always moves on
  `PMLA_ASSERT_NEXT(a_pipe_moves, clk_i, rst_ni, in_valid_q && !out_valid_q, out_valid_q)

endmodule

FILE: test/tb_pin_lock_motion_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin lock motion alarm testbench
// Feeds key and Z sample beats through the alarm lock under random gaps and
// back-pressure. A behavioural copy of the lock predicts every result beat,
// which is compared field by field as the block hands it over, across a range
// of window and motion limit settings.
// ----------------------------------------------------------------------------
module tb_pin_lock_motion_alarm;

  localparam int PIN_LEN      = 4;
  localparam int PIPE_LAT     = 2;       // input register plus result register
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 950;
  localparam int NUM_PHASES   = 6;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 150;     // long receiver hold-off
  localparam logic [1:0] CFG_SPARE = 2'd3; // index with no register behind it

  // --------------------------------------------------------------------------
  // DUT wiring; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni     = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index  = '0;
  logic [15:0]        cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               mode       = 1'b0;
  logic [7:0]         key_code   = '0;
  logic signed [15:0] z_sample   = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [1:0]         lock_state;
  logic               buzzer_on;
  logic [2:0]         event_code;
  logic [2:0]         digits_entered;

  pin_lock_motion_alarm #(.PIN_LENGTH(PIN_LEN)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .key_code_i      (key_code),
    .z_sample_i      (z_sample),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .lock_state_o    (lock_state),
    .buzzer_on_o     (buzzer_on),
    .event_code_o    (event_code),
    .digits_entered_o(digits_entered)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the lock: state, PIN, entry buffer and limits
  // --------------------------------------------------------------------------
  pmla_pkg::lock_state_e sh_state;
  logic [7:0]            sh_pin   [PIN_LEN];
  logic [7:0]            sh_entry [PIN_LEN];
  int unsigned           sh_count;
  logic [7:0]            sh_motion;
  logic                  sh_siren;
  logic signed [15:0]    sh_zlo;
  logic signed [15:0]    sh_zhi;
  logic [7:0]            sh_mlimit;

  pmla_pkg::item_t   tx_beats     [$];   // beats waiting for the driver
  pmla_pkg::result_t want_results [$];   // predicted result beats, oldest first

  int beats_in     = 0;
  int beats_acted  = 0;        // accepted beats the lock did not just ignore
  int results_seen = 0;
  int errors       = 0;
  int cfg_writes   = 0;
  int cycle_cnt    = 0;
  int ev_tally [0:4] = '{default: 0};

  logic squeeze = 1'b0;        // set during the long hold so the sender skips its random gaps
  logic hold_on = 1'b0;        // receiver held off for the long stretch

  function automatic void wipe_entry();
    for (int k = 0; k < PIN_LEN; k++) sh_entry[k] = '0;
    sh_count = 0;
  endfunction

  // One beat through the shadow lock; acted is low when the beat is ignored.
  function automatic pmla_pkg::result_t advance_lock(input pmla_pkg::item_t it,
                                                     output bit acted);
    pmla_pkg::result_t  r;
    pmla_pkg::event_e   ev;
    logic signed [15:0] z;
    bit                 same;
    ev    = pmla_pkg::EV_NONE;
    acted = 1'b1;
    z     = it.z_sample;
    if (it.mode == 1'b0) begin
      if (it.key_code == pmla_pkg::KEY_NONE || sh_state == pmla_pkg::LOCK_ARMED) begin
        acted = 1'b0;
      end else if (it.key_code == pmla_pkg::KEY_CLEAR) begin
        wipe_entry();
      end else if (it.key_code == pmla_pkg::KEY_ENTER) begin
        if (sh_state == pmla_pkg::LOCK_DISARMED) begin
          // only a full entry arms; an early enter does nothing
          if (sh_count == PIN_LEN) begin
            for (int k = 0; k < PIN_LEN; k++) sh_pin[k] = sh_entry[k];
            wipe_entry();
            sh_state = pmla_pkg::LOCK_ARMED;
            ev       = pmla_pkg::EV_ARMED;
          end else begin
            acted = 1'b0;
          end
        end else begin
          // disarming: short entry counts as a wrong PIN
          same = (sh_count == PIN_LEN);
          for (int k = 0; k < PIN_LEN; k++) if (sh_entry[k] != sh_pin[k]) same = 1'b0;
          if (same) begin
            sh_siren = 1'b0;
            sh_state = pmla_pkg::LOCK_DISARMED;
            ev       = pmla_pkg::EV_DISARMED;
          end else begin
            ev = pmla_pkg::EV_WRONG;
          end
          wipe_entry();
        end
      end else if (sh_count < PIN_LEN) begin
        sh_entry[sh_count] = it.key_code;
        sh_count++;
      end else begin
        acted = 1'b0;                // entry full, digit dropped
      end
    end else if (sh_state != pmla_pkg::LOCK_ARMED) begin
      acted = 1'b0;                  // samples only matter while armed
    end else if (z < sh_zlo || z > sh_zhi) begin
      if (sh_motion != pmla_pkg::MOTION_CNT_TOP) sh_motion++;
      if (sh_motion >= sh_mlimit) begin
        sh_siren  = 1'b1;
        wipe_entry();
        sh_motion = '0;
        sh_state  = pmla_pkg::LOCK_DISARMING;
        ev        = pmla_pkg::EV_ALARM;
      end
    end else begin
      sh_motion = '0;
    end
    r.lock_state     = sh_state;
    r.buzzer_on      = sh_siren;
    r.event_code     = ev;
    r.digits_entered = 3'(sh_count);
    return r;
  endfunction

  // Gap length for either side: mostly none or short, a few long, with calm
  // stretches of back-to-back beats.
  function automatic int draw_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("tb: %s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver: pops pending beats, holds valid and payload until accepted, and
  // predicts the result at the edge that takes the beat
  // --------------------------------------------------------------------------
  pmla_pkg::item_t cur_beat;
  int              tx_gap  = 0;
  int              tx_calm = 0;

  always @(posedge clk_i) begin : tx_side
    pmla_pkg::result_t r;
    bit                acted;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = advance_lock(cur_beat, acted);
        want_results.push_back(r);
        beats_in++;
        if (acted) beats_acted++;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (tx_gap > 0 && !squeeze) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tx_beats.size() > 0) begin
          cur_beat = tx_beats.pop_front();
          in_valid <= 1'b1;
          mode     <= cur_beat.mode;
          key_code <= cur_beat.key_code;
          z_sample <= cur_beat.z_sample;
          tx_gap   = draw_idle(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: counted in cycles, started every few hundred results
  // --------------------------------------------------------------------------
  int hold_cnt     = 0;
  int next_hold_at = 300;

  always @(posedge clk_i) begin : hold_ctl
    if (!rst_ni) begin
      hold_on  <= 1'b0;
      squeeze  <= 1'b0;
      hold_cnt = 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) begin
        hold_on <= 1'b0;
        squeeze <= 1'b0;
      end
    end else if (results_seen >= next_hold_at) begin
      hold_cnt     = HOLD_CYCLES;
      next_hold_at = next_hold_at + 400;
      hold_on      <= 1'b1;
      squeeze      <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction and
  // drives out_ready
  // --------------------------------------------------------------------------
  int rx_stall = 0;
  int rx_calm  = 0;

  always @(posedge clk_i) begin : rx_side
    pmla_pkg::result_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_results.size() == 0) begin
          flag_error($sformatf({"result beat with nothing expected: ",
                                "state %0d buzzer %0b event %0d digits %0d"},
                               lock_state, buzzer_on, event_code, digits_entered));
        end else begin
          e = want_results.pop_front();
          results_seen++;
          ev_tally[e.event_code]++;
          if (lock_state !== e.lock_state || buzzer_on !== e.buzzer_on ||
              event_code !== e.event_code || digits_entered !== e.digits_entered) begin
            flag_error($sformatf({"result %0d mismatch: expected state %0d buzzer %0b ",
                                  "event %0d digits %0d, got %0d %0b %0d %0d"},
                                 results_seen, e.lock_state, e.buzzer_on, e.event_code,
                                 e.digits_entered, lock_state, buzzer_on, event_code,
                                 digits_entered));
          end
        end
      end
      if (hold_on) begin
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        rx_stall = draw_idle(rx_calm);
        if (rx_stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rx_stall--;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_key(input logic [7:0] code);
    pmla_pkg::item_t b;
    b.mode     = 1'b0;
    b.key_code = code;
    b.z_sample = 16'($urandom);    // unused field still toggles
    tx_beats.push_back(b);
  endtask

  task automatic queue_z(input logic signed [15:0] z);
    pmla_pkg::item_t b;
    b.mode     = 1'b1;
    b.key_code = 8'($urandom);     // unused field still toggles
    b.z_sample = z;
    tx_beats.push_back(b);
  endtask

  task automatic queue_noise();
    pmla_pkg::item_t b;
    int              r;
    r          = $urandom_range(0, 5);
    b.mode     = 1'($urandom);
    b.key_code = (r == 0) ? pmla_pkg::KEY_CLEAR :
                 (r == 1) ? pmla_pkg::KEY_ENTER :
                 (r == 2) ? pmla_pkg::KEY_NONE  : 8'($urandom);
    b.z_sample = 16'($urandom);
    tx_beats.push_back(b);
  endtask

  // A digit-like key: decimal, A-D, or any code that is not a control key.
  function automatic logic [7:0] rand_code();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = "0" + 8'($urandom_range(0, 9));
      1: c = "A" + 8'($urandom_range(0, 3));
      default: begin
        do c = 8'($urandom);
        while (c == pmla_pkg::KEY_NONE || c == pmla_pkg::KEY_CLEAR ||
               c == pmla_pkg::KEY_ENTER);
      end
    endcase
    return c;
  endfunction

  // Z value inside or outside the current window, with bounds now and then.
  // Falls back to any value when the window makes the request impossible.
  function automatic logic signed [15:0] pick_z(input bit outside);
    int lo;
    int hi;
    int r;
    lo = sh_zlo;
    hi = sh_zhi;
    r  = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (outside) begin
      if (r < 3 && lo > -32768) return 16'(lo - 1);
      if (r < 5 && hi < 32767) return 16'(hi + 1);
      if (lo > -32768 && (hi >= 32767 || r[0]))
        return 16'(-32768 + $urandom_range(lo + 32767, 0));
      if (hi < 32767) return 16'(hi + 1 + $urandom_range(32766 - hi, 0));
      return 16'($urandom);
    end
    if (lo > hi) return 16'($urandom);
    if (r < 3) return 16'(lo);
    if (r < 5) return 16'(hi);
    return 16'(lo + $urandom_range(hi - lo, 0));
  endfunction

  // Next short sequence, shaped by where the lock is now: arm when disarmed,
  // motion runs when armed, unlock attempts when disarming; some plain noise.
  task automatic queue_scenario();
    int r;
    int n;
    int bad;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) queue_noise();
    end else begin
      case (sh_state)
        pmla_pkg::LOCK_DISARMED: begin
          if ($urandom_range(0, 4) != 0) queue_key(pmla_pkg::KEY_CLEAR);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PIN_LEN + 2) : PIN_LEN;
          repeat (n) queue_key(rand_code());
          queue_key(pmla_pkg::KEY_ENTER);
        end
        pmla_pkg::LOCK_ARMED: begin
          if (r < 45) begin
            // enough motion to trip the alarm from a cleared count
            n = (sh_mlimit == 0) ? 1 : sh_mlimit;
            repeat (n) queue_z(pick_z(1'b1));
          end else begin
            n = $urandom_range(1, 4);
            repeat (n) queue_z(pick_z(1'b1));
            if ($urandom_range(0, 4) == 0) queue_key(rand_code());
            queue_z(pick_z(1'b0));
          end
        end
        pmla_pkg::LOCK_DISARMING: begin
          if (r < 70) begin
            if ($urandom_range(0, 1) != 0) queue_key(pmla_pkg::KEY_CLEAR);
            for (int k = 0; k < PIN_LEN; k++) queue_key(sh_pin[k]);
          end else begin
            // short entry or one code off
            n   = $urandom_range(0, PIN_LEN);
            bad = $urandom_range(0, PIN_LEN - 1);
            for (int k = 0; k < n; k++)
              queue_key((k == bad) ? sh_pin[k] ^ 8'($urandom_range(1, 255)) : sh_pin[k]);
            if ($urandom_range(0, 3) == 0) queue_key(pmla_pkg::KEY_CLEAR);
          end
          queue_key(pmla_pkg::KEY_ENTER);
        end
        default: queue_noise();
      endcase
    end
  endtask

  // Register write; only issued with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pmla_pkg::CFG_Z_LOW:     sh_zlo    = val;
      pmla_pkg::CFG_Z_HIGH:    sh_zhi    = val;
      pmla_pkg::CFG_MOTION_LM: sh_mlimit = val[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Status is polled on the falling edge, clear of the rising-edge updates.
  task automatic wait_drained();
    do @(negedge clk_i); while (tx_beats.size() != 0 || in_valid || want_results.size() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed beats, then random phases per setting
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int                 goal;
    int                 t;
    logic signed [15:0] zl;
    logic signed [15:0] zh;
    logic [15:0]        ml_word;

    sh_state  = pmla_pkg::LOCK_DISARMED;
    for (int k = 0; k < PIN_LEN; k++) sh_pin[k] = pmla_pkg::PIN_RESET_CODE;
    wipe_entry();
    sh_motion = '0;
    sh_siren  = 1'b0;
    sh_zlo    = pmla_pkg::Z_LOW_RESET;
    sh_zhi    = pmla_pkg::Z_HIGH_RESET;
    sh_mlimit = pmla_pkg::MOTION_LIMIT_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats at the reset limits
    queue_key(pmla_pkg::KEY_NONE);      // no key
    queue_z(16'sd30000);                // sample while disarmed
    queue_key(pmla_pkg::KEY_ENTER);     // early enter, empty entry
    queue_key("A");
    queue_key("B");
    queue_key("C");
    queue_key("D");
    queue_key("9");                     // entry already full
    queue_key(pmla_pkg::KEY_CLEAR);
    queue_key("7");
    queue_key(8'hFF);
    queue_key("C");
    queue_key("1");
    queue_key(pmla_pkg::KEY_ENTER);     // arms with the new PIN
    queue_key("5");                     // keys ignored while armed
    queue_z(16'sh8000);                 // motion, count 1
    queue_z(16'sd20000);                // window edges are quiet
    queue_z(16'sd12000);
    queue_z(16'sd11999);
    queue_z(16'sd20001);
    queue_z(16'sh8000);
    queue_z(16'sh7FFF);
    queue_z(16'sd11999);                // fifth in a row: alarm
    queue_key(pmla_pkg::KEY_ENTER);     // short entry, wrong PIN
    queue_key("7");
    queue_key(8'hFF);
    queue_key("C");
    queue_key("1");
    queue_key(pmla_pkg::KEY_ENTER);     // disarms
    wait_drained();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      ml_word = '0;
      case (p)
        1: begin                          // narrow random window, low limit
          zl = 16'(int'($urandom_range(0, 40000)) - 20000);
          t  = zl;
          t  = t + int'($urandom_range(0, 12000));
          if (t > 32767) t = 32767;
          zh = 16'(t);
          ml_word[7:0] = 8'($urandom_range(1, 6));
        end
        2: begin                          // widest window, top limit
          zl = 16'sh8000;
          zh = 16'sh7FFF;
          ml_word[7:0] = 8'hFF;
        end
        3: begin                          // inverted window, zero limit
          zl = 16'sh7FFF;
          zh = 16'sh8000;
          ml_word[7:0] = 8'h00;
        end
        4: begin                          // single-point window, junk in upper bits
          zl = 16'($urandom);
          zh = zl;
          ml_word = {8'($urandom), 8'd1};
        end
        5: begin                          // reset window, longest motion run
          zl = pmla_pkg::Z_LOW_RESET;
          zh = pmla_pkg::Z_HIGH_RESET;
          ml_word[7:0] = 8'hFF;
        end
        default: begin
          zl = 16'($urandom);
          zh = 16'($urandom);
          ml_word[7:0] = 8'($urandom_range(1, 10));
        end
      endcase
      write_reg(pmla_pkg::CFG_Z_LOW, zl);
      write_reg(pmla_pkg::CFG_Z_HIGH, zh);
      write_reg(pmla_pkg::CFG_MOTION_LM, ml_word);
      if (p == 4) write_reg(CFG_SPARE, 16'($urandom));

      // shared beat budget; a long run in one phase shortens the next
      goal = (RANDOM_ITEMS * p) / NUM_PHASES;
      do begin
        do @(negedge clk_i); while (tx_beats.size() != 0 || in_valid);
        queue_scenario();
      end while (beats_in < goal);
      wait_drained();
    end

    $display("tb: %0d beats sent (%0d acted on), %0d results checked, %0d register writes, %0d cycles",
             beats_in, beats_acted, results_seen, cfg_writes, cycle_cnt);
    $display("tb: events: %0d armed, %0d alarms, %0d disarmed, %0d wrong PIN; %0d mismatches",
             ev_tally[pmla_pkg::EV_ARMED], ev_tally[pmla_pkg::EV_ALARM],
             ev_tally[pmla_pkg::EV_DISARMED], ev_tally[pmla_pkg::EV_WRONG], errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
